/* sv/avcsc_pkg.sv */
// Shared types and constants for the length-prefix to start-code converter.
package avcsc_pkg;

  // Parsing phase of the decoder configuration record.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE_HI,
    PH_SIZE_LO,
    PH_DATA,
    PH_PPS_CNT,
    PH_DONE
  } phase_t;

  // What the back end has to emit for one queued command.
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_START,
    CMD_MARK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  localparam logic [7:0] START_CODE_ZERO    = 8'h00;
  localparam logic [7:0] START_CODE_LAST    = 8'h01;
  localparam logic [7:0] SPS_COUNT_MASK     = 8'h1f;
  localparam logic [2:0] RESET_PREFIX_BYTES = 3'd4;
  localparam logic [2:0] THREE_BYTE_PREFIX  = 3'd3;
  localparam logic [2:0] HDR_PREFIX_INDEX   = 3'd4;
  localparam logic [2:0] HDR_SPS_INDEX      = 3'd5;
  localparam logic [2:0] HDR_INDEX_MAX      = 3'd7;
  localparam logic [1:0] START_CODE_FINAL   = 2'd3;

endpackage

/* sv/avcsc_if.sv */
// Handshake channel interfaces for input items and result items.
interface avcsc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source(output valid, output op, output data_byte, output buffer_end, input ready);
  modport sink(input valid, input op, input data_byte, input buffer_end, output ready);
endinterface

interface avcsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_out;

  modport source(output valid, output out_byte, output byte_valid, output last_out, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input last_out, output ready);
endinterface

/* sv/avcsc_front.sv */
// Front end: parses record and access-unit bytes and issues output commands.
module avcsc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [7:0]       data_byte,
  input  logic             buffer_end,
  output logic             cmd_valid,
  output avcsc_pkg::cmd_t  cmd,
  input  logic             cmd_ready
);

  avcsc_pkg::phase_t phase, phase_next, e_phase;
  logic [2:0]  header_index, header_index_next, e_hidx;
  logic [7:0]  sets_left, sets_left_next, e_sets;
  logic        in_pps_list, in_pps_list_next, e_pps;
  logic [2:0]  prefix_bytes, prefix_bytes_next;
  logic [2:0]  prefix_count, prefix_count_next, e_pcount;
  logic [31:0] length_accum, length_accum_next, e_accum;
  logic [31:0] bytes_remaining, bytes_remaining_next, e_rem;
  logic        previous_op;

  logic        accept;
  logic        rem_nz, rem_one;
  logic [31:0] rem_dec, acc_shift, size_word;
  logic [2:0]  pcount_inc;
  logic        prefix_full;
  logic [7:0]  sets_dec;
  avcsc_pkg::phase_t finish_phase;
  logic        push;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && cmd_ready;

  // State as the model sees it once the op change has restarted counters.
  always_comb begin
    e_phase  = phase;
    e_hidx   = header_index;
    e_sets   = sets_left;
    e_pps    = in_pps_list;
    e_accum  = length_accum;
    e_rem    = bytes_remaining;
    e_pcount = prefix_count;
    if (!op && previous_op) begin
      e_phase = avcsc_pkg::PH_HEADER;
      e_hidx  = '0;
      e_sets  = '0;
      e_pps   = 1'b0;
      e_accum = '0;
      e_rem   = '0;
    end
    if (op && !previous_op) begin
      e_pcount = '0;
      e_rem    = '0;
      e_accum  = '0;
    end
  end

  assign rem_nz      = (e_rem != '0);
  assign rem_one     = (e_rem == 32'd1);
  assign rem_dec     = e_rem - 32'd1;
  assign pcount_inc  = e_pcount + 3'd1;
  assign prefix_full = (pcount_inc >= prefix_bytes);
  assign acc_shift   = {((e_pcount == '0) ? 24'd0 : e_accum[23:0]), data_byte};
  assign size_word   = e_accum | {24'd0, data_byte};
  assign sets_dec    = e_sets - 8'd1;

  always_comb begin
    if (sets_dec != '0) begin
      finish_phase = avcsc_pkg::PH_SIZE_HI;
    end else if (!e_pps) begin
      finish_phase = avcsc_pkg::PH_PPS_CNT;
    end else begin
      finish_phase = avcsc_pkg::PH_DONE;
    end
  end

  // Next state.
  always_comb begin
    phase_next           = e_phase;
    header_index_next    = e_hidx;
    sets_left_next       = e_sets;
    in_pps_list_next     = e_pps;
    prefix_bytes_next    = prefix_bytes;
    prefix_count_next    = e_pcount;
    length_accum_next    = e_accum;
    bytes_remaining_next = e_rem;
    if (!op) begin
      unique case (e_phase)
        avcsc_pkg::PH_HEADER: begin
          if (e_hidx == avcsc_pkg::HDR_PREFIX_INDEX) begin
            prefix_bytes_next = {1'b0, data_byte[1:0]} + 3'd1;
          end else if (e_hidx == avcsc_pkg::HDR_SPS_INDEX) begin
            sets_left_next   = data_byte & avcsc_pkg::SPS_COUNT_MASK;
            in_pps_list_next = 1'b0;
            phase_next = ((data_byte & avcsc_pkg::SPS_COUNT_MASK) != '0) ?
                         avcsc_pkg::PH_SIZE_HI : avcsc_pkg::PH_PPS_CNT;
          end
          if (e_hidx < avcsc_pkg::HDR_INDEX_MAX) begin
            header_index_next = e_hidx + 3'd1;
          end
        end
        avcsc_pkg::PH_SIZE_HI: begin
          length_accum_next = {16'd0, data_byte, 8'd0};
          phase_next        = avcsc_pkg::PH_SIZE_LO;
        end
        avcsc_pkg::PH_SIZE_LO: begin
          length_accum_next    = size_word;
          bytes_remaining_next = size_word;
          if (size_word == '0) begin
            sets_left_next = sets_dec;
            phase_next     = finish_phase;
          end else begin
            phase_next = avcsc_pkg::PH_DATA;
          end
        end
        avcsc_pkg::PH_DATA: begin
          if (rem_nz) begin
            bytes_remaining_next = rem_dec;
          end
          if (!rem_nz || rem_one) begin
            sets_left_next = sets_dec;
            phase_next     = finish_phase;
          end
        end
        avcsc_pkg::PH_PPS_CNT: begin
          sets_left_next   = data_byte;
          in_pps_list_next = 1'b1;
          phase_next = (data_byte != '0) ? avcsc_pkg::PH_SIZE_HI : avcsc_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end else begin
      if (rem_nz) begin
        bytes_remaining_next = rem_dec;
      end else begin
        length_accum_next = acc_shift;
        if (prefix_full) begin
          prefix_count_next    = '0;
          bytes_remaining_next = (prefix_bytes == avcsc_pkg::THREE_BYTE_PREFIX) ?
                                 32'd0 : acc_shift;
        end else begin
          prefix_count_next = pcount_inc;
        end
      end
      if (buffer_end) begin
        bytes_remaining_next = '0;
        prefix_count_next    = '0;
        length_accum_next    = '0;
      end
    end
  end

  // Command issued for this item.
  always_comb begin
    push      = 1'b0;
    cmd.kind  = avcsc_pkg::CMD_BYTE;
    cmd.data  = data_byte;
    cmd.last  = 1'b0;
    if (!op) begin
      unique case (e_phase)
        avcsc_pkg::PH_SIZE_LO: begin
          push     = 1'b1;
          cmd.kind = avcsc_pkg::CMD_START;
        end
        avcsc_pkg::PH_DATA: begin
          push = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      if (rem_nz) begin
        push = 1'b1;
      end else if (prefix_full) begin
        push     = 1'b1;
        cmd.kind = avcsc_pkg::CMD_START;
      end
      if (buffer_end) begin
        if (!push) begin
          cmd.kind = avcsc_pkg::CMD_MARK;
          cmd.data = '0;
        end
        push     = 1'b1;
        cmd.last = 1'b1;
      end
    end
  end

  assign cmd_valid = in_valid && push;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= avcsc_pkg::PH_HEADER;
      header_index    <= '0;
      sets_left       <= '0;
      in_pps_list     <= 1'b0;
      prefix_bytes    <= avcsc_pkg::RESET_PREFIX_BYTES;
      prefix_count    <= '0;
      length_accum    <= '0;
      bytes_remaining <= '0;
      previous_op     <= 1'b1;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      sets_left       <= sets_left_next;
      in_pps_list     <= in_pps_list_next;
      prefix_bytes    <= prefix_bytes_next;
      prefix_count    <= prefix_count_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
      previous_op     <= op;
    end
  end

endmodule

/* sv/avcsc_queue.sv */
// Short command queue between the front end and the back end.
module avcsc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  avcsc_pkg::cmd_t  push_cmd,
  output logic             not_full,
  output logic             head_valid,
  output avcsc_pkg::cmd_t  head,
  input  logic             pop
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  avcsc_pkg::cmd_t slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok, pop_ok;

  assign not_full   = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push_ok    = push_valid && not_full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/avcsc_back.sv */
// Back end: expands queued commands into result items in an output register.
module avcsc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  avcsc_pkg::cmd_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last_out
);

  logic [1:0] seq;
  logic       load;
  logic       sc_final;

  assign load     = !out_valid || out_ready;
  assign sc_final = (seq == avcsc_pkg::START_CODE_FINAL);
  assign pop      = load && head_valid && ((head.kind != avcsc_pkg::CMD_START) || sc_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        seq <= (head.kind == avcsc_pkg::CMD_START) ? seq + 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      case (head.kind)
        avcsc_pkg::CMD_START: begin
          out_byte   <= sc_final ? avcsc_pkg::START_CODE_LAST : avcsc_pkg::START_CODE_ZERO;
          byte_valid <= 1'b1;
          last_out   <= head.last && sc_final;
        end
        avcsc_pkg::CMD_MARK: begin
          out_byte   <= '0;
          byte_valid <= 1'b0;
          last_out   <= 1'b1;
        end
        default: begin
          out_byte   <= head.data;
          byte_valid <= 1'b1;
          last_out   <= head.last;
        end
      endcase
    end
  end

endmodule

/* sv/avc_length_prefix_to_start_code.sv */
// Top level of the length-prefix to start-code byte stream converter.
// With the queue empty, an accepted item is queued, then loaded into the output register.
// Throughput: one item per cycle while the queue has room; each start code occupies
// the output for four result items, so sustained rate is set by the output register
// and the command queue of QUEUE_DEPTH entries that absorbs start-code bursts.
// Reset: synchronous, clears parser, queue and output; prefix length returns to four.
module avc_length_prefix_to_start_code #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  avcsc_in_if.sink    din,
  avcsc_out_if.source dout
);

  // The front end parses each item in the cycle it is accepted and issues at
  // most one command: a data byte, a start code (four result items) or a bare
  // end marker. The buffer-end flag rides on the command as its last mark.
  logic             cmd_valid;
  avcsc_pkg::cmd_t  cmd;
  logic             q_not_full;

  // Queue head seen by the back end.
  logic             head_valid;
  avcsc_pkg::cmd_t  head;
  logic             pop;

  avcsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .op         (din.op),
    .data_byte  (din.data_byte),
    .buffer_end (din.buffer_end),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (q_not_full)
  );

  // The queue decouples the parser from the output: the input keeps flowing, until
  // the queue fills, while a start code is being expanded or the sink stalls.
  avcsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_cmd   (cmd),
    .not_full   (q_not_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The back end turns commands into result items, one per cycle while the sink
  // takes them, in an output register that reloads whenever it is empty or being taken.
  avcsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_byte   (dout.out_byte),
    .byte_valid (dout.byte_valid),
    .last_out   (dout.last_out)
  );

endmodule

/* sv/avcsc_checker.sv */
// Port-level checker for the converter, bound to the top level.
module avcsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last_out
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(byte_valid) && $stable(last_out))
    else $error("result changed while stalled");

  // A bare end marker always closes the buffer and carries a zero byte.
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_out && (out_byte == 8'h00))
    else $error("malformed end marker");

  // Nothing is left in the output right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // The queue is empty after reset, so input is taken at once.
  a_reset_ready: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind avc_length_prefix_to_start_code avcsc_checker u_avcsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .out_byte   (dout.out_byte),
  .byte_valid (dout.byte_valid),
  .last_out   (dout.last_out)
);

/* test/avc_length_prefix_to_start_code_test.sv */
// Self-checking testbench for the length-prefix to start-code converter.
module avc_length_prefix_to_start_code_test;

  // Item kinds on the input channel.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_UNIT   = 1'b1;

  localparam int RANDOM_ITEMS = 110;
  localparam int CALM_ITEMS   = 30;
  localparam int LONG_HOLD    = 250;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_DIRECTED   = 26;

  // How a directed row is checked: by the predictor, or against a result typed in the table.
  typedef enum {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_START,
    ROW_START_LAST,
    ROW_MARK,
    ROW_BYTE
  } row_check_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       eob;
    row_check_t chk;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       is_last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  avcsc_in_if  in_ch();
  avcsc_out_if out_ch();

  avc_length_prefix_to_start_code uut (
    .clk (clk),
    .rst (rst),
    .din (in_ch),
    .dout(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed part. It opens on access unit bytes right after reset, so the
  // reset prefix length of four is in force, then walks one full record and
  // the special cases around prefixes and buffer ends.
  stim_row_t directed_rows [N_DIRECTED] = '{
    // Zero-length NAL with the reset prefix length, closing the buffer.
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b1, ROW_START_LAST},
    // Record restart; buffer_end on a record byte is ignored.
    '{OP_RECORD, 8'h00, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'h11, 1'b1, ROW_SILENT},
    '{OP_RECORD, 8'h22, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'h33, 1'b0, ROW_SILENT},
    // Prefix length three; one SPS with the upper count bits set.
    '{OP_RECORD, 8'hfe, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'he1, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'h00, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'h01, 1'b0, ROW_START},
    '{OP_RECORD, 8'h67, 1'b0, ROW_BYTE},
    // One PPS of size zero, then an extra byte past the end of the record.
    '{OP_RECORD, 8'h01, 1'b0, ROW_PREDICT},
    '{OP_RECORD, 8'h00, 1'b0, ROW_SILENT},
    '{OP_RECORD, 8'h00, 1'b0, ROW_START},
    '{OP_RECORD, 8'hff, 1'b0, ROW_SILENT},
    // Three-byte prefix gives an empty NAL; then a prefix cut by the buffer end.
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'hff, 1'b0, ROW_START},
    '{OP_UNIT,   8'h80, 1'b1, ROW_MARK},
    // A record of one byte keeps the prefix length of three.
    '{OP_RECORD, 8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h00, 1'b0, ROW_SILENT},
    '{OP_UNIT,   8'h01, 1'b1, ROW_START_LAST},
    // A fresh one-byte prefix ending the buffer is dropped.
    '{OP_UNIT,   8'h7f, 1'b1, ROW_MARK}
  };

  // Predictor state, as it stands after reset.
  avcsc_pkg::phase_t rec_phase = avcsc_pkg::PH_HEADER;
  logic [2:0]  hdr_pos   = 3'd0;
  logic [7:0]  sets_todo = 8'd0;
  logic        pps_list  = 1'b0;
  logic [2:0]  pfx_len   = avcsc_pkg::RESET_PREFIX_BYTES;
  logic [2:0]  pfx_seen  = 3'd0;
  logic [31:0] nal_len   = 32'd0;
  logic [31:0] copy_left = 32'd0;
  logic        in_unit   = 1'b1;

  result_t step_results[$];
  result_t due_stream[$];

  int  items_sent = 0;
  int  results_taken = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  task automatic put_start_code(input logic is_last);
    repeat (3) step_results.push_back('{avcsc_pkg::START_CODE_ZERO, 1'b1, 1'b0});
    step_results.push_back('{avcsc_pkg::START_CODE_LAST, 1'b1, is_last});
  endtask

  // A parameter set is done: go on to the next one, the PPS count, or the tail.
  task automatic close_set();
    sets_todo = sets_todo - 8'd1;
    if (sets_todo != 8'd0) begin
      rec_phase = avcsc_pkg::PH_SIZE_HI;
    end else if (!pps_list) begin
      rec_phase = avcsc_pkg::PH_PPS_CNT;
    end else begin
      rec_phase = avcsc_pkg::PH_DONE;
    end
  endtask

  // Works out the byte-stream output that one accepted input byte causes.
  task automatic convert_byte(input logic op, input logic [7:0] b, input logic eob);
    step_results.delete();
    if (op == OP_RECORD) begin
      // A record byte after unit bytes starts a new record.
      if (in_unit) begin
        rec_phase = avcsc_pkg::PH_HEADER;
        hdr_pos   = 3'd0;
        sets_todo = 8'd0;
        pps_list  = 1'b0;
        nal_len   = 32'd0;
        copy_left = 32'd0;
      end
      in_unit = 1'b0;
      case (rec_phase)
        avcsc_pkg::PH_HEADER: begin
          if (hdr_pos == avcsc_pkg::HDR_PREFIX_INDEX) begin
            pfx_len = {1'b0, b[1:0]} + 3'd1;
          end else if (hdr_pos == avcsc_pkg::HDR_SPS_INDEX) begin
            sets_todo = b & avcsc_pkg::SPS_COUNT_MASK;
            pps_list  = 1'b0;
            rec_phase = (sets_todo != 8'd0) ? avcsc_pkg::PH_SIZE_HI : avcsc_pkg::PH_PPS_CNT;
          end
          if (hdr_pos < avcsc_pkg::HDR_INDEX_MAX) hdr_pos = hdr_pos + 3'd1;
        end
        avcsc_pkg::PH_SIZE_HI: begin
          nal_len   = {16'd0, b, 8'd0};
          rec_phase = avcsc_pkg::PH_SIZE_LO;
        end
        avcsc_pkg::PH_SIZE_LO: begin
          nal_len   = nal_len | {24'd0, b};
          put_start_code(1'b0);
          copy_left = nal_len;
          if (copy_left == 32'd0) begin
            close_set();
          end else begin
            rec_phase = avcsc_pkg::PH_DATA;
          end
        end
        avcsc_pkg::PH_DATA: begin
          step_results.push_back('{b, 1'b1, 1'b0});
          if (copy_left != 32'd0) copy_left = copy_left - 32'd1;
          if (copy_left == 32'd0) close_set();
        end
        avcsc_pkg::PH_PPS_CNT: begin
          sets_todo = b;
          pps_list  = 1'b1;
          rec_phase = (sets_todo != 8'd0) ? avcsc_pkg::PH_SIZE_HI : avcsc_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end else begin
      // The first unit byte after record bytes clears the prefix and copy counters.
      if (!in_unit) begin
        pfx_seen  = 3'd0;
        copy_left = 32'd0;
        nal_len   = 32'd0;
      end
      in_unit = 1'b1;
      if (copy_left != 32'd0) begin
        step_results.push_back('{b, 1'b1, 1'b0});
        copy_left = copy_left - 32'd1;
      end else begin
        if (pfx_seen == 3'd0) nal_len = 32'd0;
        nal_len  = {nal_len[23:0], b};
        pfx_seen = pfx_seen + 3'd1;
        if (pfx_seen >= pfx_len) begin
          put_start_code(1'b0);
          copy_left = (pfx_len == avcsc_pkg::THREE_BYTE_PREFIX) ? 32'd0 : nal_len;
          pfx_seen  = 3'd0;
        end
      end
      // The buffer end flags the last result, or stands alone as a bare marker.
      if (eob) begin
        if (step_results.size() == 0) begin
          step_results.push_back('{avcsc_pkg::START_CODE_ZERO, 1'b0, 1'b1});
        end else begin
          step_results[step_results.size() - 1].is_last = 1'b1;
        end
        copy_left = 32'd0;
        pfx_seen  = 3'd0;
        nal_len   = 32'd0;
      end
    end
  endtask

  // Offers one item, waits for it to be taken, then queues what it should produce.
  // Called at a rising edge; returns at the edge that accepted the item.
  task automatic send_item(input logic op, input logic [7:0] b, input logic eob,
                           input row_check_t chk);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.data_byte  <= b;
    in_ch.buffer_end <= eob;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    convert_byte(op, b, eob);
    // The predictor always runs so that its state follows the block; typed rows
    // replace its results with the ones written in the table.
    case (chk)
      ROW_PREDICT: begin
        foreach (step_results[i]) due_stream.push_back(step_results[i]);
      end
      ROW_START: begin
        repeat (3) due_stream.push_back('{avcsc_pkg::START_CODE_ZERO, 1'b1, 1'b0});
        due_stream.push_back('{avcsc_pkg::START_CODE_LAST, 1'b1, 1'b0});
      end
      ROW_START_LAST: begin
        repeat (3) due_stream.push_back('{avcsc_pkg::START_CODE_ZERO, 1'b1, 1'b0});
        due_stream.push_back('{avcsc_pkg::START_CODE_LAST, 1'b1, 1'b1});
      end
      ROW_MARK: due_stream.push_back('{avcsc_pkg::START_CODE_ZERO, 1'b0, 1'b1});
      ROW_BYTE: due_stream.push_back('{b, 1'b1, 1'b0});
      default: begin
      end
    endcase
  endtask

  task automatic send_sets(input int count);
    int size;
    for (int i = 0; i < count; i++) begin
      size = $urandom_range(0, 3);
      send_item(OP_RECORD, 8'h00, 1'($urandom_range(0, 1)), ROW_PREDICT);
      send_item(OP_RECORD, 8'(size), 1'($urandom_range(0, 1)), ROW_PREDICT);
      repeat (size) send_item(OP_RECORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              ROW_PREDICT);
    end
  endtask

  // A full record with a random prefix length and a few short parameter sets,
  // or a record cut short before the prefix length or the SPS count is read.
  task automatic send_record(input bit cut_short);
    int n_sets;
    if (cut_short) begin
      repeat ($urandom_range(1, 5))
        send_item(OP_RECORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ROW_PREDICT);
    end else begin
      repeat (5)
        send_item(OP_RECORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ROW_PREDICT);
      n_sets = $urandom_range(0, 2);
      send_item(OP_RECORD, {3'($urandom_range(0, 7)), 5'(n_sets)}, 1'b0, ROW_PREDICT);
      send_sets(n_sets);
      n_sets = $urandom_range(0, 2);
      send_item(OP_RECORD, 8'(n_sets), 1'b0, ROW_PREDICT);
      send_sets(n_sets);
      repeat ($urandom_range(0, 1))
        send_item(OP_RECORD, 8'($urandom_range(0, 255)), 1'b0, ROW_PREDICT);
    end
  endtask

  // An access unit of one to three NALs framed with the prefix length in force.
  // Now and then the buffer ends early, inside a prefix or a payload.
  task automatic send_unit();
    logic [7:0] unit_bytes[$];
    int n_nal;
    int plen;
    int stop;
    n_nal = $urandom_range(1, 3);
    for (int i = 0; i < n_nal; i++) begin
      plen = $urandom_range(0, 4);
      for (int k = 1; k <= pfx_len; k++) unit_bytes.push_back((k == pfx_len) ? 8'(plen) : 8'h00);
      if (pfx_len != avcsc_pkg::THREE_BYTE_PREFIX)
        repeat (plen) unit_bytes.push_back(8'($urandom_range(0, 255)));
    end
    stop = unit_bytes.size() - 1;
    if ($urandom_range(0, 4) == 0) stop = $urandom_range(0, stop);
    for (int i = 0; i <= stop; i++) send_item(OP_UNIT, unit_bytes[i], i == stop, ROW_PREDICT);
  endtask

  // Random junk; the last item is a unit byte that closes the buffer, so the
  // next record starts clean.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      send_item((i == n - 1) ? OP_UNIT : 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)), ROW_PREDICT);
    end
  endtask

  // Sender: reset, the directed table, then random buffers.
  initial begin
    int pick;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_RECORD;
    in_ch.data_byte   <= 8'h00;
    in_ch.buffer_end  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].eob,
                directed_rows[i].chk);

    // Mostly well-formed buffers with random content, some broken ones and noise.
    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      calm = (items_sent >= N_DIRECTED + RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_noise();
      end else begin
        send_record(pick == 1);
        send_unit();
      end
    end
    in_ch.valid <= 1'b0;

    while (due_stream.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: checks each taken result against the oldest one due, and stalls
  // in random bursts. Once it holds off for a long stretch so that the block's
  // queue fills and the input stalls.
  initial begin
    int  stall_left;
    int  hold_left;
    bit  held_long;
    result_t due;
    stall_left = 0;
    hold_left  = 0;
    held_long  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (due_stream.size() == 0) begin
          $display("%0t: unexpected result: byte %02h valid %0b last %0b", $time,
                   out_ch.out_byte, out_ch.byte_valid, out_ch.last_out);
          mismatch_count++;
        end else begin
          due = due_stream.pop_front();
          if (out_ch.out_byte !== due.data || out_ch.byte_valid !== due.vld ||
              out_ch.last_out !== due.is_last) begin
            $display("%0t: mismatch: expected byte %02h valid %0b last %0b, got byte %02h valid %0b last %0b",
                     $time, due.data, due.vld, due.is_last,
                     out_ch.out_byte, out_ch.byte_valid, out_ch.last_out);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held_long && results_taken >= HOLD_AFTER) begin
        held_long = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still due", $time, due_stream.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule
